/* design/ring_buffer_deque_assert.svh */
// Assertion macros for the deque RTL
`ifndef RING_BUFFER_DEQUE_ASSERT_SVH
`define RING_BUFFER_DEQUE_ASSERT_SVH

// Property that must hold every cycle outside reset
`define RBD_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Next-cycle implication
`define RBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/rbd_pkg.sv */
package rbd_pkg;
  localparam int KIND_W = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W = 10;
  localparam int ERR_W = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ       = 3'd4;
  localparam logic [KIND_W-1:0] KIND_REVERSE    = 3'd5;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;
  localparam logic [ERR_W-1:0] ERR_RANGE = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
  } cmd_t;
endpackage

/* design/ring_buffer_deque.sv */
// Double-ended queue in a ring RAM of DEPTH words. Commands enter through a
// two-entry queue (push/full) and results leave through a one-entry register
// (empty/pop). Push front/back and rejected commands finish in the executor's
// idle state, pop and read pass through one registered RAM read, and reverse
// of N elements swaps floor(N/2) element pairs over the single RAM port pair:
// each swap is two reads and two writes. A new command starts once the prior
// result has been taken. DATA_WIDTH up to 32 is carried on the 32-bit ports.
module ring_buffer_deque
  import rbd_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [POS_W-1:0]   in_position,
  output logic               empty,
  input  logic               pop,
  output logic [VALUE_W-1:0] out_data,
  output logic [$clog2(DEPTH+1)-1:0] out_count,
  output logic [ERR_W-1:0]   out_error
);
  cmd_t cmd_in, cmd_q;
  logic cmd_valid, cmd_take, res_valid;

  assign cmd_in = '{kind: in_kind, value: in_value, position: in_position};
  assign empty  = !res_valid;

  rbd_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .cmd_in(cmd_in), .full(full),
    .cmd_valid(cmd_valid), .cmd_out(cmd_q), .cmd_take(cmd_take)
  );

  rbd_back #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd_q),
    .cmd_take(cmd_take), .res_valid(res_valid), .res_data(out_data),
    .res_count(out_count), .res_error(out_error), .res_pop(pop)
  );
endmodule

/* design/rbd_ram.sv */
module rbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* design/rbd_front.sv */
// Two-entry command queue; separates input handshake from the executor.
module rbd_front
  import rbd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t cmd_in,
  output logic full,
  output logic cmd_valid,
  output cmd_t cmd_out,
  input  logic cmd_take
);
  cmd_t       slot_r [2];
  logic       rd_ptr_r, rd_ptr_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_wr, do_rd;

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd_out   = slot_r[rd_ptr_r];
  assign do_wr     = push && !full;
  assign do_rd     = cmd_take && cmd_valid;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r ^ do_rd;
    wr_ptr_nxt = wr_ptr_r ^ do_wr;
    cnt_nxt    = cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end
endmodule

/* design/rbd_back.sv */
module rbd_back
  import rbd_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               cmd_take,
  output logic               res_valid,
  output logic [VALUE_W-1:0] res_data,
  output logic [$clog2(DEPTH+1)-1:0] res_count,
  output logic [ERR_W-1:0]   res_error,
  input  logic               res_pop
);
  `include "ring_buffer_deque_assert.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_RV_A = 3'd2;
  localparam logic [2:0] ST_RV_B = 3'd3;
  localparam logic [2:0] ST_RV_W = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]  st_r, st_nxt;
  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] ia_r, ia_nxt, ib_r, ib_nxt;
  logic [CW-1:0] pairs_r, pairs_nxt;
  logic [DATA_WIDTH-1:0] tmp_r, tmp_nxt;
  logic [VALUE_W-1:0] data_r, data_nxt;
  logic [ERR_W-1:0] err_r, err_nxt;
  logic          valid_r, valid_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata, rdata;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] i);
    return (i == LAST) ? '0 : i + 1'b1;
  endfunction
  function automatic logic [AW-1:0] dec(input logic [AW-1:0] i);
    return (i == '0) ? LAST : i - 1'b1;
  endfunction
  function automatic logic [AW-1:0] addm(input logic [AW-1:0] a, input logic [POS_W-1:0] b);
    logic [AW+POS_W:0] s;
    logic [AW+POS_W:0] m;
    m = (AW+POS_W+1)'(DEPTH);
    s = (AW+POS_W+1)'(a) + (AW+POS_W+1)'(b);
    // b < count <= DEPTH and a < DEPTH, so one subtract suffices
    if (s >= m) s = s - m;
    return s[AW-1:0];
  endfunction

  rbd_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic start;
  assign start     = (st_r == ST_IDLE) && cmd_valid && !valid_r;
  assign cmd_take  = start;
  assign res_valid = valid_r;
  assign res_data  = data_r;
  assign res_count = cnt_r;
  assign res_error = err_r;

  always_comb begin
    st_nxt = st_r; head_nxt = head_r; tail_nxt = tail_r; cnt_nxt = cnt_r;
    ia_nxt = ia_r; ib_nxt = ib_r; pairs_nxt = pairs_r; tmp_nxt = tmp_r;
    data_nxt = data_r; err_nxt = err_r; valid_nxt = valid_r;
    we = 1'b0; waddr = '0; wdata = cmd.value[DATA_WIDTH-1:0]; raddr = '0;
    if (valid_r && res_pop) valid_nxt = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (start) begin
          data_nxt = '0;
          err_nxt  = ERR_OK;
          case (cmd.kind)
            KIND_PUSH_FRONT: begin
              if (cnt_r == CW'(DEPTH)) err_nxt = ERR_FULL;
              else begin
                head_nxt = dec(head_r); we = 1'b1; waddr = dec(head_r);
                cnt_nxt = cnt_r + 1'b1;
              end
              valid_nxt = 1'b1;
            end
            KIND_PUSH_BACK: begin
              if (cnt_r == CW'(DEPTH)) err_nxt = ERR_FULL;
              else begin
                we = 1'b1; waddr = tail_r; tail_nxt = inc(tail_r);
                cnt_nxt = cnt_r + 1'b1;
              end
              valid_nxt = 1'b1;
            end
            KIND_POP_FRONT: begin
              if (cnt_r == '0) begin
                err_nxt = ERR_EMPTY; valid_nxt = 1'b1;
              end else begin
                raddr = head_r; head_nxt = inc(head_r); cnt_nxt = cnt_r - 1'b1;
                st_nxt = ST_RD;
              end
            end
            KIND_POP_BACK: begin
              if (cnt_r == '0) begin
                err_nxt = ERR_EMPTY; valid_nxt = 1'b1;
              end else begin
                raddr = dec(tail_r); tail_nxt = dec(tail_r); cnt_nxt = cnt_r - 1'b1;
                st_nxt = ST_RD;
              end
            end
            KIND_READ: begin
              if ((POS_W+CW)'(cmd.position) >= (POS_W+CW)'(cnt_r)) begin
                err_nxt = ERR_RANGE; valid_nxt = 1'b1;
              end else begin
                raddr = addm(head_r, cmd.position); st_nxt = ST_RD;
              end
            end
            KIND_REVERSE: begin
              pairs_nxt = cnt_r >> 1;
              ia_nxt = head_r; ib_nxt = dec(tail_r);
              if ((cnt_r >> 1) == '0) valid_nxt = 1'b1;
              else st_nxt = ST_RV_A;
            end
            default: valid_nxt = 1'b1;
          endcase
        end
      end
      ST_RD: begin
        data_nxt = VALUE_W'(rdata);
        valid_nxt = 1'b1;
        st_nxt = ST_IDLE;
      end
      // swap step: read a, read b (latch a), write a, write b
      ST_RV_A: begin
        raddr = ia_r; st_nxt = ST_RV_B;
      end
      ST_RV_B: begin
        raddr = ib_r; tmp_nxt = rdata; st_nxt = ST_RV_W;
      end
      ST_RV_W: begin
        we = 1'b1; waddr = ia_r; wdata = rdata; st_nxt = ST_OUT;
      end
      ST_OUT: begin
        we = 1'b1; waddr = ib_r; wdata = tmp_r;
        ia_nxt = inc(ia_r); ib_nxt = dec(ib_r); pairs_nxt = pairs_r - 1'b1;
        if (pairs_r == CW'(1)) begin
          valid_nxt = 1'b1; st_nxt = ST_IDLE;
        end else st_nxt = ST_RV_A;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; head_r <= '0; tail_r <= '0; cnt_r <= '0; valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt; head_r <= head_nxt; tail_r <= tail_nxt; cnt_r <= cnt_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ia_r <= ia_nxt; ib_r <= ib_nxt; pairs_r <= pairs_nxt; tmp_r <= tmp_nxt;
    data_r <= data_nxt; err_r <= err_nxt;
  end

  // distance from head to tail around the ring; equal pointers mean empty or full
  logic [CW-1:0] ptr_span;
  assign ptr_span = CW'(tail_r) - CW'(head_r)
                  + ((tail_r < head_r || cnt_r == CW'(DEPTH)) ? CW'(DEPTH) : CW'(0));

  `RBD_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CW'(DEPTH), "count exceeds depth")
  `RBD_ASSERT_ALWAYS(a_ptr_cnt, ptr_span == cnt_r, "pointers disagree with count")
  `RBD_ASSERT_NEXT(a_hold, valid_r && !res_pop, valid_r && $stable(data_r) && $stable(cnt_r), "result changed while waiting")
  `RBD_ASSERT_ALWAYS(a_no_busy_out, !(valid_r && st_r != ST_IDLE), "result shown while busy")
endmodule
